### rtl/pds_pkg.sv
`default_nettype none

package pds_pkg;

    // Default size of the mantissa table for one decade of pH.
    localparam int MANT_DEFAULT = 100;

    // Divider operand widths: the widest dividend is the tank product, the
    // widest divisor is ten to the eleventh power.
    localparam int NUM_W = 44;
    localparam int DEN_W = 37;

    // Configuration port geometry.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes.
    localparam logic [2:0] REG_TARGET     = 3'd0;
    localparam logic [2:0] REG_TOL_LOW    = 3'd1;
    localparam logic [2:0] REG_TOL_HIGH   = 3'd2;
    localparam logic [2:0] REG_SOLUTION   = 3'd3;
    localparam logic [2:0] REG_TANK       = 3'd4;
    localparam logic [2:0] REG_PUMP_RATE  = 3'd5;
    localparam logic [2:0] REG_MIXING     = 3'd6;
    localparam logic [2:0] REG_LOW_LEVEL  = 3'd7;

    // Sequencer phases.
    localparam logic [1:0] PH_COMPUTE = 2'd0;
    localparam logic [1:0] PH_PUMP    = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;

    localparam logic [19:0] DOSE_MAX    = 20'hFFFFF;
    localparam logic [17:0] DAY_SECONDS = 18'd86400;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    typedef struct packed {
        logic        [10:0] setpoint_ph;
        logic signed [11:0] tolerance_low;
        logic        [10:0] tolerance_high;
        logic        [14:0] solution_millimolar;
        logic        [13:0] tank_liters;
        logic        [9:0]  pump_rate;
        logic        [16:0] mixing_seconds;
        logic        [7:0]  low_level_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SPLIT,
        CMD_INDEX,
        CMD_FETCH,
        CMD_DIV_M2,
        CMD_DIFF,
        CMD_MUL_TANK,
        CMD_DIV_CONC,
        CMD_TAKE_B,
        CMD_SCALE_UP,
        CMD_DIV_SCALE,
        CMD_VOL,
        CMD_DOSE_MUL,
        CMD_DIV_RATE,
        CMD_COMMIT
    } cmd_t;

    typedef struct packed {
        logic       gate_open;
        logic [1:0] phase;
        logic       gap_big;
        logic       e_small;
        logic       up_done;
        logic       div_done;
    } dp_status_t;

    typedef struct packed {
        logic [10:0] q;
        logic [6:0]  r;
    } dm100_t;

    // Quotient and remainder by 100 for values below 2^17: a reciprocal
    // product that never overshoots, then one correction step.
    function automatic dm100_t div100(input logic [16:0] x);
        logic [29:0] prod;
        logic [10:0] q;
        logic [17:0] rem;
        dm100_t      res;
        prod = 30'(x) * 30'd5242;
        q    = prod[29:19];
        rem  = 18'(x) - 18'(q) * 18'd100;
        if (rem >= 18'd100) begin
            q   = q + 11'd1;
            rem = rem - 18'd100;
        end
        res.q = q;
        res.r = rem[6:0];
        return res;
    endfunction

    // Powers of ten used as divisors.
    function automatic logic [DEN_W-1:0] pow10(input logic [3:0] k);
        logic [DEN_W-1:0] p;
        case (k)
            4'd0:    p = 37'd1;
            4'd1:    p = 37'd10;
            4'd2:    p = 37'd100;
            4'd3:    p = 37'd1000;
            4'd4:    p = 37'd10000;
            4'd5:    p = 37'd100000;
            4'd6:    p = 37'd1000000;
            4'd7:    p = 37'd10000000;
            4'd8:    p = 37'd100000000;
            4'd9:    p = 37'd1000000000;
            4'd10:   p = 37'd10000000000;
            4'd11:   p = 37'd100000000000;
            default: p = 37'd1;
        endcase
        return p;
    endfunction

    // Truncating Q30 power, used only while elaborating the table.
    function automatic longint unsigned qpow(input longint unsigned r, input int n);
        longint unsigned x;
        x = Q30_ONE;
        for (int k = 0; k < n; k++) begin
            x = (x * r) >> 30;
        end
        return x;
    endfunction

    // Smallest Q30 ratio whose n-fold power reaches one tenth.
    function automatic longint unsigned find_ratio(input int n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 64'd0;
        hi = Q30_ONE;
        while (hi - lo > 64'd1) begin
            mid = (lo + hi) / 2;
            if (qpow(mid, n) >= Q30_ONE / 10) begin
                hi = mid;
            end else begin
                lo = mid;
            end
        end
        return hi;
    endfunction

    // Table entry k: the ratio raised to k by repeated Q30 products.
    function automatic longint unsigned mant_at(input int k, input longint unsigned r);
        return qpow(r, k);
    endfunction

endpackage

`default_nettype wire

### rtl/pds_regs.sv
`default_nettype none

module pds_regs
    import pds_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register file with its power-on defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint_ph         <= 11'd600;
            cfg_reg.tolerance_low       <= -12'sd20;
            cfg_reg.tolerance_high      <= 11'd20;
            cfg_reg.solution_millimolar <= 15'd1470;
            cfg_reg.tank_liters         <= 14'd100;
            cfg_reg.pump_rate           <= 10'd10;
            cfg_reg.mixing_seconds      <= 17'd300;
            cfg_reg.low_level_limit     <= 8'd15;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TARGET:    cfg_reg.setpoint_ph         <= pwdata[10:0];
                REG_TOL_LOW:   cfg_reg.tolerance_low       <= $signed(pwdata[11:0]);
                REG_TOL_HIGH:  cfg_reg.tolerance_high      <= pwdata[10:0];
                REG_SOLUTION:  cfg_reg.solution_millimolar <= pwdata[14:0];
                REG_TANK:      cfg_reg.tank_liters         <= pwdata[13:0];
                REG_PUMP_RATE: cfg_reg.pump_rate           <= pwdata[9:0];
                REG_MIXING:    cfg_reg.mixing_seconds      <= pwdata[16:0];
                REG_LOW_LEVEL: cfg_reg.low_level_limit     <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_idx)
            REG_TARGET:    prdata = 32'(cfg_reg.setpoint_ph);
            REG_TOL_LOW:   prdata = 32'($unsigned(cfg_reg.tolerance_low));
            REG_TOL_HIGH:  prdata = 32'(cfg_reg.tolerance_high);
            REG_SOLUTION:  prdata = 32'(cfg_reg.solution_millimolar);
            REG_TANK:      prdata = 32'(cfg_reg.tank_liters);
            REG_PUMP_RATE: prdata = 32'(cfg_reg.pump_rate);
            REG_MIXING:    prdata = 32'(cfg_reg.mixing_seconds);
            REG_LOW_LEVEL: prdata = 32'(cfg_reg.low_level_limit);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/pds_divider.sv
`default_nettype none

module pds_divider
    import pds_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quot,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             ge;

    // One restoring step per cycle, quotient bits shift in behind the dividend.
    assign rem_sh   = {rem_reg, q_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign quot     = q_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/pds_datapath.sv
`default_nettype none

module pds_datapath
    import pds_pkg::*;
#(
    parameter int MANTISSA_ENTRIES = MANT_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire cmd_t        cmd,
    output dp_status_t       stat,
    input  wire logic        level_start,
    input  wire logic        level_stop,
    input  wire logic [10:0] measured_ph,
    input  wire logic [7:0]  water_level,
    input  wire logic [16:0] time_of_day,
    output logic [7:0]       drive_flags,
    output logic [11:0]      ph_error,
    output logic [19:0]      dose_seconds,
    output logic [1:0]       phase
);

    localparam int IDX_W = $clog2(MANTISSA_ENTRIES);
    localparam longint unsigned RATIO = find_ratio(MANTISSA_ENTRIES);
    localparam logic [16:0] ENT17 = 17'(MANTISSA_ENTRIES);
    localparam logic [10:0] ENT11 = 11'(MANTISSA_ENTRIES);

    localparam int F_PIPE    = 0;
    localparam int F_HOLD    = 1;
    localparam int F_OUT_ON  = 2;
    localparam int F_OUT_OFF = 3;
    localparam int F_IN_ON   = 4;
    localparam int F_IN_OFF  = 5;
    localparam int F_MIXER   = 6;
    localparam int F_ACID    = 7;

    localparam logic [1:0] SIGN_IDLE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // Mantissa table for one decade, built at elaboration.
    logic [30:0] mant_rom [MANTISSA_ENTRIES];

    for (genvar k = 0; k < MANTISSA_ENTRIES; k++)
    begin : g_mant
        assign mant_rom[k] = 31'(mant_at(k, RATIO));
    end

    // Captured poll.
    logic        gate_reg;
    logic [10:0] meas_reg;
    logic [7:0]  level_reg;
    logic [16:0] now_reg;

    // Work registers of the volume computation.
    logic [4:0]       e_reg;
    logic [4:0]       gap_reg;
    logic [6:0]       rlo_reg;
    logic [6:0]       rhi_reg;
    logic [IDX_W-1:0] idx_lo_reg;
    logic [IDX_W-1:0] idx_hi_reg;
    logic [30:0]      m1_reg;
    logic [30:0]      m2_reg;
    logic [30:0]      d_reg;
    logic [NUM_W-1:0] prod_reg;
    logic [61:0]      acc_reg;
    logic             sat_reg;
    logic [3:0]       cnt_reg;

    // Architectural state.
    logic [1:0]         phase_reg;
    logic               timer_armed_reg;
    logic [1:0]         last_sign_reg;
    logic [16:0]        start_time_reg;
    logic [19:0]        dose_time_reg;
    logic signed [11:0] error_reg;
    logic [31:0]        volume_reg;
    logic [7:0]         flags_reg;

    logic [1:0]         phase_next;
    logic               armed_next;
    logic [1:0]         sign_next;
    logic [16:0]        start_next;
    logic [19:0]        dose_next;
    logic signed [11:0] error_next;
    logic [7:0]         flags_next;

    // Divider link.
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_quot;
    logic             div_done;

    // Combinational helpers.
    logic [10:0]  plo;
    logic [10:0]  phi;
    dm100_t       dm_lo;
    dm100_t       dm_hi;
    dm100_t       ix_lo;
    dm100_t       ix_hi;
    logic [30:0]  m2q;
    logic [30:0]  d_val;
    logic [65:0]  acc_ext;
    logic [65:0]  acc_up;
    logic         e_small;
    logic [19:0]  dose_calc;
    logic signed [11:0] err_new;
    logic signed [11:0] th;
    logic signed [11:0] tl;
    logic         level_low;
    logic [17:0]  now_wrap;
    logic signed [18:0] el_diff;
    logic [17:0]  elapsed;
    logic         in_dose;
    logic         in_mix;

    assign e_small = e_reg <= 5'd9;

    // pH split into decade and position inside the decade.
    assign plo   = (cfg.setpoint_ph < meas_reg) ? cfg.setpoint_ph : meas_reg;
    assign phi   = (cfg.setpoint_ph < meas_reg) ? meas_reg : cfg.setpoint_ph;
    assign dm_lo = div100(17'(plo));
    assign dm_hi = div100(17'(phi));
    assign ix_lo = div100(17'(rlo_reg) * ENT17);
    assign ix_hi = div100(17'(rhi_reg) * ENT17);

    // Difference of the two mantissas, floored at zero.
    assign m2q   = (gap_reg >= 5'd10) ? 31'd0 : div_quot[30:0];
    assign d_val = (m1_reg >= m2q) ? (m1_reg - m2q) : 31'd0;

    // One decimal scaling step of the volume.
    assign acc_ext = 66'(acc_reg);
    assign acc_up  = (acc_ext << 3) + (acc_ext << 1);

    assign dose_calc = (div_quot > NUM_W'(DOSE_MAX)) ? DOSE_MAX : div_quot[19:0];

    // Error and band limits.
    assign err_new   = $signed(12'(cfg.setpoint_ph)) - $signed(12'(meas_reg));
    assign th        = $signed({1'b0, cfg.tolerance_high});
    assign tl        = cfg.tolerance_low;
    assign level_low = level_reg < cfg.low_level_limit;

    // Seconds since dose start, with midnight wrap.
    assign now_wrap = (now_reg < start_time_reg) ? (18'(now_reg) + DAY_SECONDS)
                                                 : 18'(now_reg);
    assign el_diff  = $signed({1'b0, now_wrap}) - $signed(19'(start_time_reg));
    assign elapsed  = el_diff[18] ? 18'd0 : el_diff[17:0];
    assign in_dose  = {3'b0, elapsed} < {1'b0, dose_time_reg};
    assign in_mix   = {3'b0, elapsed} < (21'(dose_time_reg) + 21'(cfg.mixing_seconds));

    // Divider operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_num   = prod_reg;
        div_den   = DEN_W'(1);
        case (cmd)
            CMD_DIV_M2:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(m2_reg);
                div_den   = pow10(gap_reg[3:0]);
            end
            CMD_DIV_CONC:
            begin
                div_start = 1'b1;
                div_den   = (cfg.solution_millimolar == 15'd0) ? DEN_W'(1)
                                                               : DEN_W'(cfg.solution_millimolar);
            end
            CMD_DIV_SCALE:
            begin
                div_start = 1'b1;
                div_num   = acc_reg[NUM_W-1:0];
                div_den   = pow10(4'(e_reg - 5'd9));
            end
            CMD_DIV_RATE:
            begin
                div_start = 1'b1;
                div_den   = (cfg.pump_rate == 10'd0) ? DEN_W'(1) : DEN_W'(cfg.pump_rate);
            end
            default: ;
        endcase
    end

    pds_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    // Step update of the sequencer state for one poll.
    always_comb
    begin
        logic done;
        done       = 1'b0;
        phase_next = phase_reg;
        armed_next = timer_armed_reg;
        sign_next  = last_sign_reg;
        start_next = start_time_reg;
        dose_next  = dose_time_reg;
        error_next = error_reg;
        flags_next = flags_reg;
        if (gate_reg)
        begin
            case (phase_reg)
                PH_COMPUTE:
                begin
                    error_next         = err_new;
                    flags_next[F_PIPE] = (err_new > tl) && (err_new < th);
                    phase_next         = PH_PUMP;
                end
                PH_PUMP:
                begin
                    if (!timer_armed_reg)
                    begin
                        if (error_reg > 12'sd0)
                        begin
                            if (error_reg > th)
                            begin
                                start_next            = now_reg;
                                dose_next             = dose_calc;
                                armed_next            = 1'b1;
                                flags_next[F_HOLD]    = 1'b1;
                                flags_next[F_OUT_ON]  = 1'b1;
                                flags_next[F_OUT_OFF] = 1'b0;
                                flags_next[F_IN_ON]   = !level_low;
                                flags_next[F_IN_OFF]  = level_low;
                                flags_next[F_MIXER]   = 1'b1;
                            end
                            else
                            begin
                                flags_next[F_HOLD]  = 1'b0;
                                flags_next[F_MIXER] = 1'b0;
                            end
                            sign_next = SIGN_POS;
                        end
                        else if (error_reg < 12'sd0)
                        begin
                            flags_next[F_HOLD] = 1'b0;
                            if (error_reg < tl)
                            begin
                                start_next = now_reg;
                                dose_next  = dose_calc;
                                armed_next = 1'b1;
                            end
                            flags_next[F_ACID]  = error_reg < tl;
                            flags_next[F_MIXER] = error_reg < tl;
                            sign_next           = SIGN_NEG;
                        end
                    end
                    else if (error_reg < 12'sd0)
                    begin
                        if (last_sign_reg == SIGN_NEG)
                        begin
                            flags_next[F_HOLD] = 1'b0;
                            if (error_reg < tl)
                            begin
                                if (in_dose)
                                begin
                                    flags_next[F_ACID]  = 1'b1;
                                    flags_next[F_MIXER] = 1'b1;
                                end
                                else if (in_mix)
                                begin
                                    flags_next[F_ACID]  = 1'b0;
                                    flags_next[F_MIXER] = 1'b1;
                                end
                                else
                                begin
                                    flags_next[F_MIXER] = 1'b0;
                                    done                = 1'b1;
                                end
                            end
                            else
                            begin
                                done                = 1'b1;
                                flags_next[F_ACID]  = 1'b0;
                                flags_next[F_MIXER] = 1'b0;
                            end
                        end
                        else
                        begin
                            // Sign flipped under an armed positive dose.
                            flags_next[F_ACID]  = 1'b0;
                            flags_next[F_MIXER] = 1'b0;
                            armed_next          = 1'b0;
                        end
                    end
                    else if ((error_reg > 12'sd0) && (last_sign_reg == SIGN_POS))
                    begin
                        if (error_reg > th)
                        begin
                            if (in_dose)
                            begin
                                flags_next[F_HOLD]    = 1'b1;
                                flags_next[F_OUT_ON]  = 1'b1;
                                flags_next[F_OUT_OFF] = 1'b0;
                                flags_next[F_MIXER]   = 1'b1;
                                flags_next[F_IN_ON]   = !level_low;
                                flags_next[F_IN_OFF]  = level_low;
                            end
                            else if (in_mix)
                            begin
                                flags_next[F_IN_ON]   = 1'b0;
                                flags_next[F_IN_OFF]  = 1'b1;
                                flags_next[F_OUT_ON]  = 1'b0;
                                flags_next[F_OUT_OFF] = 1'b1;
                                flags_next[F_MIXER]   = 1'b1;
                                flags_next[F_HOLD]    = 1'b0;
                            end
                            else
                            begin
                                flags_next[F_MIXER] = 1'b0;
                                done                = 1'b1;
                            end
                        end
                        else
                        begin
                            flags_next[F_IN_ON]   = 1'b0;
                            flags_next[F_IN_OFF]  = 1'b1;
                            flags_next[F_OUT_ON]  = 1'b0;
                            flags_next[F_OUT_OFF] = 1'b0;
                            flags_next[F_MIXER]   = 1'b0;
                            flags_next[F_HOLD]    = 1'b0;
                        end
                    end
                    if (done)
                    begin
                        armed_next = 1'b0;
                        phase_next = PH_COMPUTE;
                    end
                    else
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = ((error_reg > tl) && (error_reg < th)) ? PH_COMPUTE : PH_PUMP;
                end
                default: ;
            endcase
        end
    end

    // Architectural state, written at most once per poll.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COMPUTE;
            timer_armed_reg <= 1'b0;
            last_sign_reg   <= SIGN_IDLE;
            start_time_reg  <= '0;
            dose_time_reg   <= '0;
            error_reg       <= '0;
            volume_reg      <= '0;
            flags_reg       <= '0;
        end
        else
        begin
            if (cmd == CMD_COMMIT)
            begin
                phase_reg       <= phase_next;
                timer_armed_reg <= armed_next;
                last_sign_reg   <= sign_next;
                start_time_reg  <= start_next;
                dose_time_reg   <= dose_next;
                error_reg       <= error_next;
                flags_reg       <= flags_next;
            end
            if (cmd == CMD_VOL)
            begin
                if (e_small)
                begin
                    volume_reg <= sat_reg ? 32'hFFFF_FFFF : acc_reg[61:30];
                end
                else
                begin
                    volume_reg <= 32'(div_quot[NUM_W-1:30]);
                end
            end
        end
    end

    // Work registers of the arithmetic sequence.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                gate_reg  <= level_start && !level_stop;
                meas_reg  <= measured_ph;
                level_reg <= water_level;
                now_reg   <= time_of_day;
            end
            CMD_SPLIT:
            begin
                e_reg   <= dm_lo.q[4:0];
                gap_reg <= 5'(dm_hi.q - dm_lo.q);
                rlo_reg <= dm_lo.r;
                rhi_reg <= dm_hi.r;
            end
            CMD_INDEX:
            begin
                idx_lo_reg <= (ix_lo.q >= ENT11) ? IDX_W'(MANTISSA_ENTRIES - 1) : IDX_W'(ix_lo.q);
                idx_hi_reg <= (ix_hi.q >= ENT11) ? IDX_W'(MANTISSA_ENTRIES - 1) : IDX_W'(ix_hi.q);
            end
            CMD_FETCH:
            begin
                m1_reg <= mant_rom[idx_lo_reg];
                m2_reg <= mant_rom[idx_hi_reg];
            end
            CMD_DIFF:
            begin
                d_reg <= d_val;
            end
            CMD_MUL_TANK:
            begin
                prod_reg <= NUM_W'(45'(d_reg) * 45'(cfg.tank_liters));
            end
            CMD_TAKE_B:
            begin
                acc_reg <= 62'(div_quot);
                sat_reg <= 1'b0;
                cnt_reg <= e_small ? 4'(5'd9 - e_reg) : 4'd0;
            end
            CMD_SCALE_UP:
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (!sat_reg)
                begin
                    if (acc_up[65:62] != 4'd0)
                    begin
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg <= acc_up[61:0];
                    end
                end
            end
            CMD_DOSE_MUL:
            begin
                prod_reg <= NUM_W'(38'(volume_reg) * 38'd42);
            end
            default: ;
        endcase
    end

    // Status toward the controller and held result fields.
    assign stat.gate_open = gate_reg;
    assign stat.phase     = phase_reg;
    assign stat.gap_big   = gap_reg >= 5'd10;
    assign stat.e_small   = e_small;
    assign stat.up_done   = cnt_reg == 4'd0;
    assign stat.div_done  = div_done;

    assign drive_flags  = flags_reg;
    assign ph_error     = error_reg;
    assign dose_seconds = dose_time_reg;
    assign phase        = phase_reg;

`ifndef ASSERT_OFF
    // An armed dose always remembers the sign that started it.
    a_armed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        timer_armed_reg |-> (last_sign_reg == SIGN_POS || last_sign_reg == SIGN_NEG))
        else $error("dose armed without a sign");

    // The fourth phase code is never entered.
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_COMPUTE || phase_reg == PH_PUMP || phase_reg == PH_CHECK)
        else $error("illegal phase");
`endif

endmodule

`default_nettype wire

### rtl/pds_ctrl.sv
`default_nettype none

module pds_ctrl
    import pds_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire dp_status_t stat,
    output cmd_t            cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SPLIT,
        S_INDEX,
        S_FETCH,
        S_M2_DIV,
        S_M2_WAIT,
        S_DIFF,
        S_MUL,
        S_CONC_DIV,
        S_CONC_WAIT,
        S_TAKE_B,
        S_UP,
        S_SC_DIV,
        S_SC_WAIT,
        S_VOL,
        S_DOSE_MUL,
        S_RATE_DIV,
        S_RATE_WAIT,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   out_free;

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = m_valid_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Next state and command for the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                cmd = CMD_SPLIT;
                if (stat.gate_open && stat.phase == PH_COMPUTE)
                begin
                    state_next = S_INDEX;
                end
                else if (stat.gate_open && stat.phase == PH_PUMP)
                begin
                    state_next = S_DOSE_MUL;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_INDEX:
            begin
                cmd        = CMD_INDEX;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd        = CMD_FETCH;
                state_next = stat.gap_big ? S_DIFF : S_M2_DIV;
            end
            S_M2_DIV:
            begin
                cmd        = CMD_DIV_M2;
                state_next = S_M2_WAIT;
            end
            S_M2_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd        = CMD_DIFF;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd        = CMD_MUL_TANK;
                state_next = S_CONC_DIV;
            end
            S_CONC_DIV:
            begin
                cmd        = CMD_DIV_CONC;
                state_next = S_CONC_WAIT;
            end
            S_CONC_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_TAKE_B;
                end
            end
            S_TAKE_B:
            begin
                cmd        = CMD_TAKE_B;
                state_next = stat.e_small ? S_UP : S_SC_DIV;
            end
            S_UP:
            begin
                if (stat.up_done)
                begin
                    state_next = S_VOL;
                end
                else
                begin
                    cmd = CMD_SCALE_UP;
                end
            end
            S_SC_DIV:
            begin
                cmd        = CMD_DIV_SCALE;
                state_next = S_SC_WAIT;
            end
            S_SC_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_VOL;
                end
            end
            S_VOL:
            begin
                cmd        = CMD_VOL;
                state_next = S_COMMIT;
            end
            S_DOSE_MUL:
            begin
                cmd        = CMD_DOSE_MUL;
                state_next = S_RATE_DIV;
            end
            S_RATE_DIV:
            begin
                cmd        = CMD_DIV_RATE;
                state_next = S_RATE_WAIT;
            end
            S_RATE_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd        = CMD_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the output beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_COMMIT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // A result beat only appears right after the state update.
    a_beat_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg) == S_COMMIT)
        else $error("result beat without commit");

    // The divider only finishes while the sequence waits for it.
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_M2_WAIT || state_reg == S_CONC_WAIT ||
                           state_reg == S_SC_WAIT || state_reg == S_RATE_WAIT))
        else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

### rtl/ph_dosing_sequencer.sv
// pH dosing sequencer.
// Input stream: one beat per poll of the level unit, pH probe, water level and
// clock. Output stream: exactly one beat per input beat carrying the drive
// flags, the latched pH error, the latched dose time and the phase after it.
// An APB port holds the eight setup registers; write them only while idle.
// Work between taking the input beat and raising the output beat:
//   gate closed or check phase: no division, only the state update;
//   pump phase: one division by the pump rate;
//   compute phase: one to three divisions in the shared bit-serial
//   divider, plus up to nine decimal scaling steps.
// Input ready is high again once the output beat is raised, so the next
// input beat can be taken while that beat still waits on the receiver.
// One poll is worked on at a time; a result may wait on a stalled receiver
// while the next poll is already being computed. The state update of that
// poll waits until the output register is free.
// Reset clears the phase, timer, drive flags and latched values, and loads
// the setup registers with their defaults.
`default_nettype none

module ph_dosing_sequencer
    import pds_pkg::*;
#(
    parameter int MANTISSA_ENTRIES = MANT_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // level_start[0], level_stop[1], measured_ph[12:2], water_level[20:13],
    // time_of_day[37:21]
    input  wire logic [39:0]        s_axis_tdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // pipe_enable[0], level_unit_hold[1], outlet_open[2], outlet_close[3],
    // inlet_open[4], inlet_close[5], mixer_on[6], acid_pump_on[7],
    // ph_error[19:8], dose_seconds[39:20], phase[41:40]
    output logic [47:0]             m_axis_tdata,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_t       cfg;
    cmd_t       cmd;
    dp_status_t stat;
    logic [7:0]  drive_flags;
    logic [11:0] ph_error;
    logic [19:0] dose_seconds;
    logic [1:0]  phase;

    pds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pds_datapath #(
        .MANTISSA_ENTRIES (MANTISSA_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .level_start  (s_axis_tdata[0]),
        .level_stop   (s_axis_tdata[1]),
        .measured_ph  (s_axis_tdata[12:2]),
        .water_level  (s_axis_tdata[20:13]),
        .time_of_day  (s_axis_tdata[37:21]),
        .drive_flags  (drive_flags),
        .ph_error     (ph_error),
        .dose_seconds (dose_seconds),
        .phase        (phase)
    );

    pds_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Result beat packing; the fields hold until the next state update.
    assign m_axis_tdata = {6'd0, phase, dose_seconds, ph_error, drive_flags};

endmodule

`default_nettype wire
